// ----- design/cmpshd_pkg.sv -----
// Shared constants, types and the arctangent table of the compass heading block.
`timescale 1ns / 1ps

package cmpshd_pkg;

    localparam int GUARD_SHIFT = 16;
    localparam int Z_BITS      = 16;
    localparam int DECL_BITS   = 13;
    localparam int DQ_BITS     = 17;
    localparam int SUM_BITS    = 18;
    localparam int H_BITS      = 16;
    localparam int DEG_BITS    = 9;

    localparam int Q_PI      = 25736;
    localparam int Q_HALF_PI = 12868;
    localparam int Q_TURN    = 51472;

    localparam int DECL_RESET   = 67;
    localparam int DECL_Q_RESET = 549;

    // Declination to Q3.13 is round(m * 8192 / 1000) = floor((1024 * m + 62) / 125).
    localparam int DECL_NUM_BITS   = 23;
    localparam int DECL_SHIFT      = 30;
    localparam int DECL_RECIP_BITS = 24;
    localparam int DECL_PROD_BITS  = DECL_NUM_BITS + DECL_RECIP_BITS;
    localparam longint unsigned DECL_RECIP = ((64'd1 << DECL_SHIFT) + 64'd124) / 64'd125;

    // Degrees are floor(h * 45 / 6434), exact for h up to one turn with this reciprocal.
    localparam int DEG_SHIFT      = 29;
    localparam int DEG_RECIP_BITS = 22;
    localparam int DEG_PROD_BITS  = H_BITS + DEG_RECIP_BITS;
    localparam longint unsigned DEG_RECIP = ((64'd45 << DEG_SHIFT) + 64'd6433) / 64'd6434;

    typedef struct packed {
        logic zero;
        logic x_neg;
        logic y_neg;
    } quad_t;

    function automatic logic signed [Z_BITS-1:0] atan_q13(input int idx);
        logic signed [Z_BITS-1:0] val;
        case (idx)
            0:       val = Z_BITS'(6434);
            1:       val = Z_BITS'(3798);
            2:       val = Z_BITS'(2007);
            3:       val = Z_BITS'(1019);
            4:       val = Z_BITS'(511);
            5:       val = Z_BITS'(256);
            6:       val = Z_BITS'(128);
            7:       val = Z_BITS'(64);
            8:       val = Z_BITS'(32);
            9:       val = Z_BITS'(16);
            10:      val = Z_BITS'(8);
            11:      val = Z_BITS'(4);
            12:      val = Z_BITS'(2);
            13:      val = Z_BITS'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- design/cmpshd_if.sv -----
// Channel interfaces for samples, headings and the declination register write.
`timescale 1ns / 1ps

interface cmpshd_sample_if #(
    parameter int AXIS_BITS = 13
);
    logic                        valid;
    logic                        ready;
    logic signed [AXIS_BITS-1:0] field_x;
    logic signed [AXIS_BITS-1:0] field_y;

    modport source (output valid, output field_x, output field_y, input ready);
    modport sink (input valid, input field_x, input field_y, output ready);
endinterface

interface cmpshd_heading_if;
    logic                              valid;
    logic                              ready;
    logic [cmpshd_pkg::DEG_BITS-1:0]   heading_deg;

    modport source (output valid, output heading_deg, input ready);
    modport sink (input valid, input heading_deg, output ready);
endinterface

interface cmpshd_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cmpshd_pkg::DECL_BITS-1:0] declination_mrad;

    modport source (output valid, output declination_mrad, input ready);
    modport sink (input valid, input declination_mrad, output ready);
endinterface

// ----- design/cmpshd_decl.sv -----
// Declination register and its conversion from milliradians to Q3.13 radians.
`timescale 1ns / 1ps

module cmpshd_decl (
    input  logic                                    clk,
    input  logic                                    rst_n,
    cmpshd_cfg_if.sink                              cfg,
    output logic signed [cmpshd_pkg::DQ_BITS-1:0]   decl_q
);

    logic signed [cmpshd_pkg::DECL_BITS-1:0]     decl_reg;
    logic signed [cmpshd_pkg::DQ_BITS-1:0]       decl_q_reg;
    logic signed [cmpshd_pkg::DQ_BITS-1:0]       decl_q_next;
    logic                                        neg;
    logic [cmpshd_pkg::DECL_BITS-1:0]            mag;
    logic [cmpshd_pkg::DECL_NUM_BITS-1:0]        num;
    logic [cmpshd_pkg::DECL_PROD_BITS-1:0]       prod;
    logic [cmpshd_pkg::H_BITS-1:0]               q;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        neg  = decl_reg[cmpshd_pkg::DECL_BITS-1];
        mag  = neg ? cmpshd_pkg::DECL_BITS'(-decl_reg) : cmpshd_pkg::DECL_BITS'(decl_reg);
        num  = {mag, 10'b0} + cmpshd_pkg::DECL_NUM_BITS'(62);
        prod = cmpshd_pkg::DECL_PROD_BITS'(num)
             * cmpshd_pkg::DECL_PROD_BITS'(cmpshd_pkg::DECL_RECIP);
        q    = prod[cmpshd_pkg::DECL_SHIFT +: cmpshd_pkg::H_BITS];
        decl_q_next = neg ? -cmpshd_pkg::DQ_BITS'(q) : cmpshd_pkg::DQ_BITS'(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg   <= cmpshd_pkg::DECL_BITS'(cmpshd_pkg::DECL_RESET);
            decl_q_reg <= cmpshd_pkg::DQ_BITS'(cmpshd_pkg::DECL_Q_RESET);
        end
        else
        begin
            if (cfg.valid)
            begin
                decl_reg <= cfg.declination_mrad;
            end
            decl_q_reg <= decl_q_next;
        end
    end

    assign decl_q = decl_q_reg;

endmodule

// ----- design/cmpshd_front.sv -----
// Input stage: takes magnitudes and signs of the field sample and scales them up.
`timescale 1ns / 1ps

module cmpshd_front #(
    parameter int AXIS_BITS = 13,
    parameter int W         = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [AXIS_BITS-1:0]   field_x,
    input  logic signed [AXIS_BITS-1:0]   field_y,
    output logic                          out_valid,
    output logic signed [W-1:0]           x_out,
    output logic signed [W-1:0]           y_out,
    output cmpshd_pkg::quad_t             quad_out
);

    logic                     valid_reg;
    logic signed [W-1:0]      x_reg;
    logic signed [W-1:0]      y_reg;
    cmpshd_pkg::quad_t        quad_reg;
    logic [AXIS_BITS-1:0]     mag_x;
    logic [AXIS_BITS-1:0]     mag_y;
    logic signed [W-1:0]      x_next;
    logic signed [W-1:0]      y_next;
    cmpshd_pkg::quad_t        quad_next;

    always_comb
    begin
        mag_x = field_x[AXIS_BITS-1] ? AXIS_BITS'(-field_x) : AXIS_BITS'(field_x);
        mag_y = field_y[AXIS_BITS-1] ? AXIS_BITS'(-field_y) : AXIS_BITS'(field_y);
        x_next = W'(mag_x) << cmpshd_pkg::GUARD_SHIFT;
        y_next = W'(mag_y) << cmpshd_pkg::GUARD_SHIFT;
        quad_next.zero  = (field_x == '0) && (field_y == '0);
        quad_next.x_neg = field_x[AXIS_BITS-1];
        quad_next.y_neg = field_y[AXIS_BITS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            quad_reg <= quad_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign quad_out  = quad_reg;

endmodule

// ----- design/cmpshd_cordic_stage.sv -----
// One registered CORDIC vectoring iteration with its fixed shift and angle.
`timescale 1ns / 1ps

module cmpshd_cordic_stage #(
    parameter int W     = 31,
    parameter int STAGE = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic signed [W-1:0]                   x_in,
    input  logic signed [W-1:0]                   y_in,
    input  logic signed [cmpshd_pkg::Z_BITS-1:0]  z_in,
    input  cmpshd_pkg::quad_t                     quad_in,
    output logic                                  out_valid,
    output logic signed [W-1:0]                   x_out,
    output logic signed [W-1:0]                   y_out,
    output logic signed [cmpshd_pkg::Z_BITS-1:0]  z_out,
    output cmpshd_pkg::quad_t                     quad_out
);

    localparam logic signed [cmpshd_pkg::Z_BITS-1:0] ANGLE = cmpshd_pkg::atan_q13(STAGE);

    logic                                  valid_reg;
    logic signed [W-1:0]                   x_reg;
    logic signed [W-1:0]                   y_reg;
    logic signed [cmpshd_pkg::Z_BITS-1:0]  z_reg;
    cmpshd_pkg::quad_t                     quad_reg;
    logic signed [W-1:0]                   dx;
    logic signed [W-1:0]                   dy;
    logic signed [W-1:0]                   x_next;
    logic signed [W-1:0]                   y_next;
    logic signed [cmpshd_pkg::Z_BITS-1:0]  z_next;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!y_in[W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            quad_reg <= quad_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign quad_out  = quad_reg;

endmodule

// ----- design/cmpshd_back.sv -----
// Back end: quadrant fix, declination add, wrap into one turn and conversion to degrees.
`timescale 1ns / 1ps

module cmpshd_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [3:0]                             adv,
    input  logic                                   in_valid,
    input  logic signed [cmpshd_pkg::Z_BITS-1:0]   z_in,
    input  cmpshd_pkg::quad_t                      quad_in,
    input  logic signed [cmpshd_pkg::DQ_BITS-1:0]  decl_q,
    output logic [3:0]                             valid,
    output logic [cmpshd_pkg::DEG_BITS-1:0]        heading_deg
);

    localparam int SB = cmpshd_pkg::SUM_BITS;
    localparam int DB = cmpshd_pkg::DQ_BITS;

    logic [3:0]                                  valid_reg;
    logic signed [DB-1:0]                        ang_reg;
    logic signed [DB-1:0]                        ang_next;
    logic [cmpshd_pkg::H_BITS-1:0]               h_reg;
    logic [cmpshd_pkg::H_BITS-1:0]               h_next;
    logic [cmpshd_pkg::DEG_PROD_BITS-1:0]        prod_reg;
    logic [cmpshd_pkg::DEG_PROD_BITS-1:0]        prod_next;
    logic [cmpshd_pkg::DEG_BITS-1:0]             deg_reg;
    logic signed [DB-1:0]                        zc;
    logic signed [DB-1:0]                        quad_ang;
    logic signed [SB-1:0]                        sum;
    logic signed [SB-1:0]                        sum_up;
    logic signed [SB-1:0]                        sum_down;
    logic signed [SB-1:0]                        turn;

    always_comb
    begin
        if (z_in < 0)
        begin
            zc = '0;
        end
        else if (DB'(z_in) > DB'(cmpshd_pkg::Q_HALF_PI))
        begin
            zc = DB'(cmpshd_pkg::Q_HALF_PI);
        end
        else
        begin
            zc = DB'(z_in);
        end
        quad_ang = quad_in.x_neg ? DB'(cmpshd_pkg::Q_PI) - zc : zc;
        if (quad_in.zero)
        begin
            ang_next = '0;
        end
        else if (quad_in.y_neg)
        begin
            ang_next = -quad_ang;
        end
        else
        begin
            ang_next = quad_ang;
        end
    end

    always_comb
    begin
        turn     = SB'(cmpshd_pkg::Q_TURN);
        sum      = SB'(ang_reg) + SB'(decl_q);
        sum_up   = sum + turn;
        sum_down = sum - turn;
        if (sum < 0)
        begin
            h_next = (sum_up < 0) ? '0 : cmpshd_pkg::H_BITS'(sum_up);
        end
        else if (sum > turn)
        begin
            h_next = cmpshd_pkg::H_BITS'(sum_down);
        end
        else
        begin
            h_next = cmpshd_pkg::H_BITS'(sum);
        end
    end

    assign prod_next = cmpshd_pkg::DEG_PROD_BITS'(h_reg)
                     * cmpshd_pkg::DEG_PROD_BITS'(cmpshd_pkg::DEG_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (adv[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (adv[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ang_reg <= ang_next;
        end
        if (adv[1])
        begin
            h_reg <= h_next;
        end
        if (adv[2])
        begin
            prod_reg <= prod_next;
        end
        if (adv[3])
        begin
            deg_reg <= prod_reg[cmpshd_pkg::DEG_SHIFT +: cmpshd_pkg::DEG_BITS];
        end
    end

    assign valid       = valid_reg;
    assign heading_deg = deg_reg;

endmodule

// ----- design/compass_heading_degrees.sv -----
// Compass heading: the top level tying the input stage, CORDIC pipeline and back end together.
// Usage: each word on the sample channel carries one signed X/Y field pair, and the block
// returns one word on the heading channel holding the heading in whole degrees, 0 to 360.
// The heading is atan2(field_y, field_x) plus the magnetic declination, wrapped into one turn.
// The cfg channel writes the declination in signed milliradians and is always ready; it is
// meant to be written while no sample is in flight, and it takes effect once the declination
// register and then its Q3.13 conversion register have loaded. From the edge that accepts a
// sample, the input stage, one register per CORDIC iteration and four back-end stages lie
// between it and its heading being valid. Throughput is one word per cycle while heading.ready
// is high, since every CORDIC iteration has its own adder stage.
// Every stage has its own valid bit and advances when it is empty or the next one advances,
// so bubbles close up and a sample is still accepted while a finished heading waits.
// When the receiver stalls, words hold in place and none is lost or repeated; sample.ready
// falls only once every stage is full.
// Reset clears all valid bits and loads a declination of 67 milliradians.
`timescale 1ns / 1ps

module compass_heading_degrees #(
    parameter int CORDIC_STAGES = 16,
    parameter int AXIS_BITS     = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    cmpshd_sample_if.sink     sample,
    cmpshd_heading_if.source  heading,
    cmpshd_cfg_if.sink        cfg
);

    localparam int W    = AXIS_BITS + cmpshd_pkg::GUARD_SHIFT + 2;
    localparam int LAST = CORDIC_STAGES + 4;

    logic [LAST:0]                          stage_valid;
    logic [LAST+1:0]                        adv;
    logic signed [W-1:0]                    cx [0:CORDIC_STAGES];
    logic signed [W-1:0]                    cy [0:CORDIC_STAGES];
    logic signed [cmpshd_pkg::Z_BITS-1:0]   cz [0:CORDIC_STAGES];
    cmpshd_pkg::quad_t                      cq [0:CORDIC_STAGES];
    logic signed [cmpshd_pkg::DQ_BITS-1:0]  decl_q;

    assign adv[LAST+1] = heading.ready;

    genvar k;
    generate
        for (k = 0; k <= LAST; k++)
        begin : g_adv
            assign adv[k] = !stage_valid[k] || adv[k+1];
        end
    endgenerate

    assign sample.ready = adv[0];
    assign cz[0]        = '0;

    cmpshd_decl u_decl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .decl_q (decl_q)
    );

    cmpshd_front #(
        .AXIS_BITS (AXIS_BITS),
        .W         (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv[0]),
        .in_valid  (sample.valid),
        .field_x   (sample.field_x),
        .field_y   (sample.field_y),
        .out_valid (stage_valid[0]),
        .x_out     (cx[0]),
        .y_out     (cy[0]),
        .quad_out  (cq[0])
    );

    generate
        for (k = 0; k < CORDIC_STAGES; k++)
        begin : g_cordic
            cmpshd_cordic_stage #(
                .W     (W),
                .STAGE (k)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv[k+1]),
                .in_valid  (stage_valid[k]),
                .x_in      (cx[k]),
                .y_in      (cy[k]),
                .z_in      (cz[k]),
                .quad_in   (cq[k]),
                .out_valid (stage_valid[k+1]),
                .x_out     (cx[k+1]),
                .y_out     (cy[k+1]),
                .z_out     (cz[k+1]),
                .quad_out  (cq[k+1])
            );
        end
    endgenerate

    cmpshd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv[LAST:LAST-3]),
        .in_valid    (stage_valid[CORDIC_STAGES]),
        .z_in        (cz[CORDIC_STAGES]),
        .quad_in     (cq[CORDIC_STAGES]),
        .decl_q      (decl_q),
        .valid       (stage_valid[LAST:LAST-3]),
        .heading_deg (heading.heading_deg)
    );

    assign heading.valid = stage_valid[LAST];

endmodule
